FILE: rtl/escape_sequence_unescaper_top_assert.svh
// ----------------------------------------------------------------------------
// escape_sequence_unescaper_top_assert.svh
// assertion macros for esu_checker, the port-level checker of the unescaper
// ----------------------------------------------------------------------------
`ifndef ESCAPE_SEQUENCE_UNESCAPER_TOP_ASSERT_SVH
`define ESCAPE_SEQUENCE_UNESCAPER_TOP_ASSERT_SVH

// same-cycle implication, masked while reset is high
`define ESU_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("unescaper check failed");

// next-cycle implication, masked while reset is high
`define ESU_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("unescaper check failed");

// next-cycle implication that also runs during reset
`define ESU_ASSERT_ALWAYS_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("unescaper check failed");

`endif

FILE: rtl/esu_pkg.sv
// ----------------------------------------------------------------------------
// esu_pkg
// types and constants of the escape sequence unescaper
// ----------------------------------------------------------------------------
package esu_pkg;

   localparam logic [7:0] CHAR_NUL    = 8'h00;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_N      = 8'h6E;
   localparam logic [7:0] CHAR_R      = 8'h72;
   localparam logic [7:0] CHAR_T      = 8'h74;
   localparam logic [7:0] CHAR_E      = 8'h65;
   localparam logic [7:0] CHAR_X      = 8'h78;

   localparam logic [7:0] BYTE_LF     = 8'h0A;
   localparam logic [7:0] BYTE_CR     = 8'h0D;
   localparam logic [7:0] BYTE_TAB    = 8'h09;
   localparam logic [7:0] BYTE_ESC    = 8'h1B;

   localparam logic [8:0] MAX_LEN_RESET = 9'd64;
   localparam logic [8:0] LIMIT_CAP     = 9'd256;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   typedef enum logic [2:0] {
      MODE_PLAIN,
      MODE_ESC,
      MODE_HEX0,
      MODE_HEX1,
      MODE_OCT1,
      MODE_OCT2,
      MODE_DROP
   } esu_mode_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_is_end;
      logic [7:0] out_length;
   } esu_result_type;

   // up to two results produced by one character
   typedef struct packed {
      logic [1:0]     count;
      esu_result_type first;
      esu_result_type second;
   } esu_push_type;

endpackage

FILE: rtl/esu_front.sv
// ----------------------------------------------------------------------------
// esu_front
// accepts characters, runs the escape decoder and pushes its results
// ----------------------------------------------------------------------------
module esu_front import esu_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [8:0]   csr_wr_data,
   input  logic         take,
   input  logic [7:0]   char_code,
   output esu_push_type push
);

   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   esu_mode_type mode_ff, mode_in, mode_base;
   logic [7:0]   pend_ff, pend_in, pend_next;
   logic [7:0]   cnt_ff, cnt_in, cnt_mid;
   logic [8:0]   max_len_ff, max_len_in;
   logic [8:0]   limit;

   logic         first_vld;
   logic [7:0]   first_byte;
   logic         plain_need;
   logic         is_oct;
   logic [4:0]   hex;
   logic [7:0]   oct_val;
   logic         lim_hit;
   logic         is_end;
   logic         plain_emit;
   esu_result_type res_data, res_end, res_plain;

   assign is_oct  = (char_code >= 8'h30) && (char_code <= 8'h37);
   assign hex     = hex_decode(char_code);
   assign oct_val = {pend_ff[4:0], 3'b000} + {5'd0, char_code[2:0]};

   // first stage: what the current mode does with the character
   always_comb begin
      first_vld  = 1'b0;
      first_byte = 8'd0;
      plain_need = 1'b0;
      pend_next  = pend_ff;
      mode_base  = MODE_PLAIN;
      unique case (mode_ff)
         MODE_ESC: begin
            unique case (char_code)
               CHAR_BSLASH: begin first_vld = 1'b1; first_byte = CHAR_BSLASH; end
               CHAR_QUOTE:  begin first_vld = 1'b1; first_byte = CHAR_QUOTE;  end
               CHAR_N:      begin first_vld = 1'b1; first_byte = BYTE_LF;     end
               CHAR_R:      begin first_vld = 1'b1; first_byte = BYTE_CR;     end
               CHAR_T:      begin first_vld = 1'b1; first_byte = BYTE_TAB;    end
               CHAR_E:      begin first_vld = 1'b1; first_byte = BYTE_ESC;    end
               CHAR_X:      mode_base = MODE_HEX0;
               default: begin
                  if (is_oct) begin
                     pend_next = {5'd0, char_code[2:0]};
                     mode_base = MODE_OCT1;
                  end else begin
                     plain_need = 1'b1;
                  end
               end
            endcase
         end
         MODE_HEX0: begin
            if (hex[4]) begin
               pend_next = {4'd0, hex[3:0]};
               mode_base = MODE_HEX1;
            end else begin
               plain_need = 1'b1;
            end
         end
         MODE_HEX1: begin
            first_vld = 1'b1;
            pend_next = 8'd0;
            if (hex[4]) begin
               first_byte = {pend_ff[3:0], hex[3:0]};
            end else begin
               first_byte = pend_ff;
               plain_need = 1'b1;
            end
         end
         MODE_OCT1, MODE_OCT2: begin
            if (is_oct) begin
               if (mode_ff == MODE_OCT1) begin
                  pend_next = oct_val;
                  mode_base = MODE_OCT2;
               end else begin
                  first_vld  = 1'b1;
                  first_byte = oct_val;
                  pend_next  = 8'd0;
               end
            end else begin
               first_vld  = 1'b1;
               first_byte = pend_ff;
               pend_next  = 8'd0;
               plain_need = 1'b1;
            end
         end
         MODE_DROP: begin
            mode_base  = MODE_DROP;
            plain_need = (char_code == CHAR_NUL);
         end
         default: plain_need = 1'b1;
      endcase
   end

   // second stage: plain character handling after any flushed value
   assign limit      = (max_len_ff > LIMIT_CAP) ? LIMIT_CAP : max_len_ff;
   assign cnt_mid    = cnt_ff + {7'd0, first_vld};
   assign lim_hit    = ({1'b0, cnt_mid} + 9'd1) >= limit;
   assign is_end     = plain_need && (char_code == CHAR_NUL);
   assign plain_emit = plain_need && (char_code != CHAR_NUL) && !lim_hit
                       && (char_code != CHAR_BSLASH);

   // next state
   always_comb begin
      mode_in = mode_ff;
      if (take) begin
         if (plain_need) begin
            priority if (char_code == CHAR_NUL) begin
               mode_in = MODE_PLAIN;
            end else if (lim_hit) begin
               mode_in = MODE_DROP;
            end else if (char_code == CHAR_BSLASH) begin
               mode_in = MODE_ESC;
            end else begin
               mode_in = MODE_PLAIN;
            end
         end else begin
            mode_in = mode_base;
         end
      end
   end

   // outputs and data registers
   always_comb begin
      res_data  = '{out_byte: first_byte, out_is_end: 1'b0, out_length: 8'd0};
      res_end   = '{out_byte: 8'd0, out_is_end: 1'b1, out_length: cnt_mid};
      res_plain = is_end ? res_end
                         : '{out_byte: char_code, out_is_end: 1'b0, out_length: 8'd0};
      push.count  = 2'd0;
      push.first  = first_vld ? res_data : res_plain;
      push.second = res_plain;
      if (take) begin
         push.count = {1'b0, first_vld} + {1'b0, is_end || plain_emit};
      end
      pend_in    = pend_ff;
      cnt_in     = cnt_ff;
      max_len_in = csr_wr_en ? csr_wr_data : max_len_ff;
      if (take) begin
         pend_in = is_end ? 8'd0 : pend_next;
         cnt_in  = is_end ? 8'd0 : cnt_mid + {7'd0, plain_emit};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_PLAIN;
         pend_ff    <= 8'd0;
         cnt_ff     <= 8'd0;
         max_len_ff <= MAX_LEN_RESET;
      end else begin
         mode_ff    <= mode_in;
         pend_ff    <= pend_in;
         cnt_ff     <= cnt_in;
         max_len_ff <= max_len_in;
      end
   end

endmodule

FILE: rtl/esu_queue.sv
// ----------------------------------------------------------------------------
// esu_queue
// short result queue between decoder and output stage, up to two writes a cycle
// ----------------------------------------------------------------------------
module esu_queue import esu_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   input  esu_push_type   push,
   output logic           ready,
   input  logic           pop,
   output logic           valid,
   output esu_result_type head
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
      return (p == AW'(DEPTH - 1)) ? AW'(0) : p + AW'(1);
   endfunction

   esu_result_type entries_ff [DEPTH];
   logic [AW-1:0]  wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [AW-1:0]  wptr_nx;

   assign wptr_nx = wrap_inc(wptr_ff);
   assign ready   = count_ff <= CW'(DEPTH - 2);
   assign valid   = count_ff != CW'(0);
   assign head    = entries_ff[rptr_ff];

   always_comb begin
      wptr_in = wptr_ff;
      if (push.count == 2'd1) begin
         wptr_in = wptr_nx;
      end else if (push.count == 2'd2) begin
         wptr_in = wrap_inc(wptr_nx);
      end
      rptr_in  = (pop && valid) ? wrap_inc(rptr_ff) : rptr_ff;
      count_in = count_ff + CW'(push.count) - CW'(pop && valid);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entries_ff[wptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         entries_ff[wptr_nx] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

endmodule

FILE: rtl/esu_back.sv
// ----------------------------------------------------------------------------
// esu_back
// output register that hands results to the receiver
// ----------------------------------------------------------------------------
module esu_back import esu_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           q_valid,
   input  esu_result_type q_head,
   output logic           q_pop,
   output logic           rsp_empty,
   input  logic           rsp_pop,
   output esu_result_type rsp_result
);

   logic           out_vld_ff, out_vld_in;
   esu_result_type out_ff;

   // refill when the register is free or its beat leaves this cycle
   assign q_pop      = q_valid && (!out_vld_ff || rsp_pop);
   assign out_vld_in = q_pop || (out_vld_ff && !rsp_pop);
   assign rsp_empty  = !out_vld_ff;
   assign rsp_result = out_ff;

   always_ff @(posedge clock) begin
      if (q_pop) begin
         out_ff <= q_head;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

endmodule

FILE: rtl/escape_sequence_unescaper_top.sv
// ----------------------------------------------------------------------------
// escape_sequence_unescaper_top
// C-style backslash escape decoder, one character per beat
// ----------------------------------------------------------------------------
// Characters enter through a queue-style port: a beat is taken when req_push
// is high and req_full is low. A zero character ends the string and yields an
// end marker carrying the decoded byte count. Decoded bytes and end markers
// leave through rsp_*: the head result is shown while rsp_empty is low and
// leaves when rsp_pop is high.
// Throughput is one character per cycle while req_full is low; each character
// makes zero, one or two results, and the output drains one result per cycle
// while rsp_pop is high. The decoder writes the result queue, then the output
// register loads from it. req_full rises when the result queue cannot take
// two more results, which happens when the receiver stalls or characters
// yield two results in a row. max_len is to be written by the user only while
// the block is idle, through csr_wr_en/csr_wr_data, which the block does not
// enforce. Synchronous reset empties the queue and the output register,
// returns the decoder to plain text with a zero count and sets max_len to 64.
// ----------------------------------------------------------------------------
module escape_sequence_unescaper_top import esu_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_char_code,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_is_end,
   output logic [7:0] rsp_out_length,
   input  logic       csr_wr_en,
   input  logic [8:0] csr_wr_data
);

   esu_push_type   push;
   esu_result_type q_head, rsp_result;
   logic           q_ready, q_valid, q_pop, take;

   assign take     = req_push && q_ready;
   assign req_full = !q_ready;

   esu_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .take        (take),
      .char_code   (req_char_code),
      .push        (push)
   );

   esu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .ready (q_ready),
      .pop   (q_pop),
      .valid (q_valid),
      .head  (q_head)
   );

   esu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_result (rsp_result)
   );

   assign rsp_out_byte   = rsp_result.out_byte;
   assign rsp_out_is_end = rsp_result.out_is_end;
   assign rsp_out_length = rsp_result.out_length;

endmodule

FILE: rtl/esu_checker.sv
// ----------------------------------------------------------------------------
// esu_checker
// port-level checks of the unescaper, bound to the top level
// ----------------------------------------------------------------------------
`include "escape_sequence_unescaper_top_assert.svh"

module esu_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_push,
   input logic       req_full,
   input logic [7:0] req_char_code,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_out_is_end,
   input logic [7:0] rsp_out_length,
   input logic       csr_wr_en,
   input logic [8:0] csr_wr_data
);

   // a stalled result beat stays and holds its payload
   `ESU_ASSERT_NEXT(a_rsp_hold, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_out_byte) && $stable(rsp_out_is_end) && $stable(rsp_out_length))

   // data beats carry no length
   `ESU_ASSERT_NOW(a_data_len_zero, !rsp_empty && !rsp_out_is_end, rsp_out_length == 8'd0)

   // end markers carry a zero byte
   `ESU_ASSERT_NOW(a_end_byte_zero, !rsp_empty && rsp_out_is_end, rsp_out_byte == 8'd0)

   // reset leaves both sides empty and open
   `ESU_ASSERT_ALWAYS_NEXT(a_reset_clear, reset, rsp_empty && !req_full)

endmodule

bind escape_sequence_unescaper_top esu_checker u_esu_checker (.*);

FILE: sim/escape_sequence_unescaper_checker.sv
// ----------------------------------------------------------------------------
// escape_sequence_unescaper_checker
// watches the unescaper's ports, decodes the same characters and compares
// ----------------------------------------------------------------------------
// Every character taken on the req_ side is decoded here into the bytes and
// end markers it must produce. These wait in order until the rsp_ side hands
// over a result, which is then compared field by field. max_len is followed
// from the csr_ writes. Mismatches and results with nothing waiting raise
// fail_count; owed_count tells the stimulus how many results are still due.
// ----------------------------------------------------------------------------
module escape_sequence_unescaper_checker import esu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic       req_full,
   input  logic [7:0] req_char_code,
   input  logic       rsp_empty,
   input  logic       rsp_pop,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_out_is_end,
   input  logic [7:0] rsp_out_length,
   input  logic       csr_wr_en,
   input  logic [8:0] csr_wr_data,
   output int         fail_count,
   output int         owed_count,
   output int         bytes_seen,
   output int         ends_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   esu_mode_type   mode;
   logic [7:0]     digits_value;
   logic [7:0]     decoded_count;
   logic [8:0]     max_len;
   esu_result_type owed_results[$];

   function automatic int hex_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
   endfunction

   function automatic bit is_octal_char(input logic [7:0] c);
      return c >= "0" && c <= "7";
   endfunction

   function automatic void put_byte(input logic [7:0] b);
      esu_result_type r;
      r.out_byte   = b;
      r.out_is_end = 1'b0;
      r.out_length = 8'd0;
      owed_results = {owed_results, r};
      decoded_count = decoded_count + 8'd1;
   endfunction

   function automatic void put_end();
      esu_result_type r;
      r.out_byte   = 8'd0;
      r.out_is_end = 1'b1;
      r.out_length = decoded_count;
      owed_results = {owed_results, r};
      mode          = MODE_PLAIN;
      digits_value  = 8'd0;
      decoded_count = 8'd0;
   endfunction

   function automatic void take_plain(input logic [7:0] c);
      logic [8:0] cap;
      cap = (max_len > LIMIT_CAP) ? LIMIT_CAP : max_len;
      if (c == CHAR_NUL) begin
         put_end();
         return;
      end
      // no room left: drop everything up to the end of the string
      if ({1'b0, decoded_count} + 9'd1 >= cap) begin
         mode = MODE_DROP;
         return;
      end
      if (c == CHAR_BSLASH) begin
         mode = MODE_ESC;
         return;
      end
      mode = MODE_PLAIN;
      put_byte(c);
   endfunction

   function automatic void decode_char(input logic [7:0] c);
      int h;
      case (mode)
         MODE_ESC: begin
            mode = MODE_PLAIN;
            case (c)
               CHAR_BSLASH: put_byte(CHAR_BSLASH);
               CHAR_QUOTE:  put_byte(CHAR_QUOTE);
               CHAR_N:      put_byte(BYTE_LF);
               CHAR_R:      put_byte(BYTE_CR);
               CHAR_T:      put_byte(BYTE_TAB);
               CHAR_E:      put_byte(BYTE_ESC);
               CHAR_X:      mode = MODE_HEX0;
               default: begin
                  if (is_octal_char(c)) begin
                     digits_value = c - "0";
                     mode = MODE_OCT1;
                  end else begin
                     // unknown escape: the character stands for itself
                     take_plain(c);
                  end
               end
            endcase
         end
         MODE_HEX0: begin
            h = hex_value(c);
            if (h >= 0) begin
               digits_value = 8'(h);
               mode = MODE_HEX1;
            end else begin
               mode = MODE_PLAIN;
               take_plain(c);
            end
         end
         MODE_HEX1: begin
            h = hex_value(c);
            mode = MODE_PLAIN;
            if (h >= 0) begin
               put_byte({digits_value[3:0], h[3:0]});
            end else begin
               put_byte(digits_value);
               take_plain(c);
            end
            digits_value = 8'd0;
         end
         MODE_OCT1, MODE_OCT2: begin
            if (is_octal_char(c)) begin
               digits_value = (digits_value << 3) + (c - "0");
               if (mode == MODE_OCT1) begin
                  mode = MODE_OCT2;
               end else begin
                  mode = MODE_PLAIN;
                  put_byte(digits_value);
                  digits_value = 8'd0;
               end
            end else begin
               mode = MODE_PLAIN;
               put_byte(digits_value);
               digits_value = 8'd0;
               take_plain(c);
            end
         end
         MODE_DROP: begin
            if (c == CHAR_NUL) put_end();
         end
         default: begin
            mode = MODE_PLAIN;
            take_plain(c);
         end
      endcase
   endfunction

   always @(posedge clock) begin
      esu_result_type want;
      if (reset) begin
         mode          = MODE_PLAIN;
         digits_value  = 8'd0;
         decoded_count = 8'd0;
         max_len       = MAX_LEN_RESET;
         owed_results.delete();
         fail_count = 0;
         bytes_seen = 0;
         ends_seen  = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (owed_results.size() == 0) begin
               fail_count++;
               $display("%0t: result beat with none expected: byte %02h end %0b length %0d",
                        $realtime, rsp_out_byte, rsp_out_is_end, rsp_out_length);
            end else begin
               want = owed_results.pop_front();
               if (rsp_out_byte !== want.out_byte || rsp_out_is_end !== want.out_is_end ||
                   rsp_out_length !== want.out_length) begin
                  fail_count++;
                  $display("%0t: mismatch: expected %02h/%0b/%0d, got %02h/%0b/%0d",
                           $realtime, want.out_byte, want.out_is_end, want.out_length,
                           rsp_out_byte, rsp_out_is_end, rsp_out_length);
               end
               if (want.out_is_end) ends_seen++;
               else bytes_seen++;
            end
         end
         if (csr_wr_en) max_len = csr_wr_data;
         if (req_push && !req_full) decode_char(req_char_code);
      end
      owed_count = owed_results.size();
   end

endmodule

FILE: sim/escape_sequence_unescaper_top_tb.sv
// ----------------------------------------------------------------------------
// escape_sequence_unescaper_top_tb
// character streams with escapes through the unescaper, checked per result
// ----------------------------------------------------------------------------
// A short directed string list covers each escape, pending digits cut by a
// new escape or the string end, and dangling escapes. Then random strings of
// well-formed and broken escapes run under a series of max_len settings,
// including 0, 1, 256 and values above 256, with long strings that hit the
// length limit. Strings may be left open across a max_len change. Both sides
// idle at random; one phase runs without gaps and one holds the result side
// off long enough to fill the block.
// ----------------------------------------------------------------------------
module escape_sequence_unescaper_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import esu_pkg::*;

   localparam int IDLE_PCT    = 31;
   localparam int HOLD_CYCLES = 300;
   localparam int CHAR_GOAL   = 1050;

   logic       clock;
   logic       reset;
   logic       req_push;
   logic       req_full;
   logic [7:0] req_char_code;
   logic       rsp_empty;
   logic       rsp_pop;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_is_end;
   logic [7:0] rsp_out_length;
   logic       csr_wr_en;
   logic [8:0] csr_wr_data;

   int fail_count;
   int owed_count;
   int bytes_seen;
   int ends_seen;

   int tx_gap_pct   = IDLE_PCT;
   int rx_stall_pct = IDLE_PCT;
   int hold_asked   = 0;
   int chars_sent   = 0;
   int settings_done = 0;

   logic [8:0] fixed_settings[$] = '{9'd1, 9'd256, 9'd0, 9'd300, 9'd2, 9'd5, 9'h1FF,
                                     9'd64, 9'd16, 9'd3};
   logic [7:0] simple_escapes[$] = '{CHAR_BSLASH, CHAR_QUOTE, CHAR_N, CHAR_R, CHAR_T, CHAR_E};
   string      hex_chars = "0123456789abcdefABCDEF";

   // each escape, pending digits cut short, dangling escapes at the string end
   logic [7:0] opening_chars[$] = '{
      CHAR_BSLASH, CHAR_BSLASH, CHAR_BSLASH, CHAR_QUOTE, CHAR_BSLASH, CHAR_N,
      CHAR_BSLASH, CHAR_R, CHAR_BSLASH, CHAR_T, CHAR_BSLASH, CHAR_E,
      CHAR_BSLASH, CHAR_X, "f", "F",
      CHAR_BSLASH, CHAR_X, "A", CHAR_BSLASH, "7", "7", "7",
      CHAR_BSLASH, "q", CHAR_NUL,
      CHAR_BSLASH, CHAR_X, CHAR_NUL,
      CHAR_BSLASH, CHAR_NUL,
      CHAR_BSLASH, "5", CHAR_NUL
   };

   escape_sequence_unescaper_top i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_char_code  (req_char_code),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_out_is_end (rsp_out_is_end),
      .rsp_out_length (rsp_out_length),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   escape_sequence_unescaper_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_char_code  (req_char_code),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_out_is_end (rsp_out_is_end),
      .rsp_out_length (rsp_out_length),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .fail_count     (fail_count),
      .owed_count     (owed_count),
      .bytes_seen     (bytes_seen),
      .ends_seen      (ends_seen)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #400000;
      $display("escape_sequence_unescaper_top_tb NOT OK");
      $finish;
   end

   // result side: random stalls, plus a long hold-off when the sender asks
   initial begin
      int hold_served;
      int hold_left;
      hold_served = 0;
      hold_left   = 0;
      rsp_pop = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= rx_stall_pct);
         end
      end
   end

   task automatic send_char(input logic [7:0] c);
      while ($urandom_range(99) < tx_gap_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push      <= 1'b1;
      req_char_code <= c;
      @(posedge clock);
      while (req_full) @(posedge clock);
      chars_sent++;
   endtask

   // stop sending and wait until every owed result has been taken
   task automatic drain();
      int waited;
      waited = 0;
      req_push <= 1'b0;
      @(posedge clock);
      while (owed_count != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      // a character that yields nothing may still be in the decoder
      repeat (4) @(posedge clock);
   endtask

   task automatic write_max_len(input logic [8:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      settings_done++;
   endtask

   function automatic logic [7:0] text_char();
      logic [7:0] c;
      c = 8'($urandom_range(8'h7E, 8'h20));
      if (c == CHAR_BSLASH) c = "A";
      return c;
   endfunction

   function automatic logic [7:0] octal_char();
      return 8'("0" + $urandom_range(7));
   endfunction

   task automatic send_token();
      int k;
      int n;
      k = $urandom_range(99);
      if (k < 40) begin
         send_char(text_char());
      end else if (k < 55) begin
         send_char(CHAR_BSLASH);
         send_char(simple_escapes[$urandom_range(simple_escapes.size() - 1)]);
      end else if (k < 65) begin
         send_char(CHAR_BSLASH);
         send_char(CHAR_X);
         n = $urandom_range(2, 1);
         repeat (n) send_char(hex_chars[$urandom_range(hex_chars.len() - 1)]);
      end else if (k < 75) begin
         send_char(CHAR_BSLASH);
         n = $urandom_range(3, 1);
         repeat (n) send_char(octal_char());
      end else if (k < 85) begin
         // broken escape: anything may follow the backslash
         send_char(CHAR_BSLASH);
         send_char(8'($urandom_range(255, 1)));
      end else if (k < 90) begin
         send_char(CHAR_BSLASH);
         send_char(CHAR_X);
         send_char(8'($urandom_range(255, 1)));
      end else begin
         send_char(8'($urandom_range(255, 1)));
      end
   endtask

   task automatic send_string(input bit close_it);
      int tokens;
      tokens = ($urandom_range(4) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
      repeat (tokens) send_token();
      if (close_it) send_char(CHAR_NUL);
   endtask

   task automatic run_setting(input logic [8:0] value, input int budget);
      int start;
      write_max_len(value);
      start = chars_sent;
      // long enough to reach the 255 byte ceiling
      if (value == LIMIT_CAP || value == 9'd300) begin
         repeat (260) send_char(text_char());
         send_char(CHAR_NUL);
         start = chars_sent;
      end
      while (chars_sent - start < budget) send_string(1'b1);
      // sometimes leave the string open across the next max_len change
      send_string(1'($urandom_range(1)));
   endtask

   initial begin
      int fail_total;
      reset         = 1'b1;
      req_push      = 1'b0;
      req_char_code = 8'd0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = 9'd0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (opening_chars[i]) send_char(opening_chars[i]);

      foreach (fixed_settings[p]) begin
         tx_gap_pct   = (p == 2) ? 0 : IDLE_PCT;
         rx_stall_pct = (p == 2) ? 0 : IDLE_PCT;
         if (p == 4) hold_asked++;
         run_setting(fixed_settings[p], 40);
      end
      while (chars_sent < CHAR_GOAL) run_setting(9'($urandom_range(256, 1)), 40);
      send_char(CHAR_NUL);

      drain();
      repeat (8) @(posedge clock);
      fail_total = fail_count + owed_count;
      $display("summary: %0d characters, %0d max_len settings, %0d bytes, %0d end markers",
               chars_sent, settings_done, bytes_seen, ends_seen);
      if (fail_total == 0) begin
         $display("escape_sequence_unescaper_top_tb OK");
      end else begin
         $display("escape_sequence_unescaper_top_tb NOT OK");
      end
      $finish;
   end

endmodule

FILE: escape_sequence_unescaper_top.f
+incdir+rtl
rtl/esu_pkg.sv
rtl/esu_front.sv
rtl/esu_queue.sv
rtl/esu_back.sv
rtl/escape_sequence_unescaper_top.sv
rtl/esu_checker.sv
sim/escape_sequence_unescaper_checker.sv
sim/escape_sequence_unescaper_top_tb.sv
